@@ src/tpmm_pkg.sv @@
package tpmm_pkg;

   // Number of tasks, each owning one row of page registers.
   localparam int TASKS = 16;
   localparam int REGS_PER_TASK = 16;
   localparam int TASK_W = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int REG_W = $clog2(REGS_PER_TASK);
   localparam int TABLE_DEPTH = TASKS * REGS_PER_TASK;
   localparam int TABLE_AW = TASK_W + REG_W;

   localparam int PAGE_BYTES = 4096;
   localparam int ROM_BYTES = 16384;
   localparam int OFF_W = $clog2(PAGE_BYTES);
   localparam int ROM_W = $clog2(ROM_BYTES);

   localparam logic [10:0] RAM_SIZE_RESET = 11'd256;
   localparam logic [7:0] DATA_NO_WRITE = 8'hC0;
   localparam logic [7:0] ROM_PAGE_LAST_PLAIN = 8'hFB;
   localparam logic [19:0] ROM_TOP_BASE = 20'h03F00;
   localparam logic [15:0] IO_START = 16'hFC00;
   localparam logic [15:0] TOP_WINDOW = 16'hFF00;
   localparam logic [15:0] ROM_UNMAPPED_START = 16'hC000;
   localparam logic [7:0] CTRL_TASK_MASK = 8'h0F;
   localparam int CTRL_MAP_OFF_BIT = 6;
   localparam int CTRL_NMI_OFF_BIT = 7;

   typedef enum logic [1:0] {
      OP_REG_WRITE = 2'd0,
      OP_REG_READ = 2'd1,
      OP_CTRL_WRITE = 2'd2,
      OP_MEM_ACCESS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TGT_RAM = 2'd0,
      TGT_ROM = 2'd1,
      TGT_IO = 2'd2
   } target_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [3:0] reg_index;
      logic [15:0] cpu_address;
      logic [7:0] data;
      logic is_write;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [19:0] phys_address;
      logic [1:0] target;
      logic write_enable;
      logic second_cpu_nmi;
      logic map_enabled;
      logic [3:0] current_task;
   } rsp_type;

   // One item on its way from the front end to the translation stage,
   // with the control state as it stands after that item.
   typedef struct packed {
      req_type item;
      logic [3:0] task_sel;
      logic map_on;
      logic nmi;
   } stage_type;

   // Task number from the low nibble of a control write, reduced modulo TASKS.
   function automatic logic [3:0] task_of(input logic [3:0] value);
      logic [4:0] v;
      v = {1'b0, value};
      for (int i = 0; i < 8; i++) begin
         if (v >= 5'(TASKS)) begin
            v = v - 5'(TASKS);
         end
      end
      return v[3:0];
   endfunction

endpackage

@@ src/tpmm_ram.sv @@
module tpmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/tpmm_table.sv @@
module tpmm_table (
   input logic clock,
   input logic reset,
   input logic wr_en,
   input logic [tpmm_pkg::TABLE_AW-1:0] wr_addr,
   input logic [7:0] wr_data,
   input logic [tpmm_pkg::TABLE_AW-1:0] rd_addr,
   output logic [7:0] rd_entry
);

   // A register that was never written since reset reads as zero.
   logic [tpmm_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [tpmm_pkg::TABLE_DEPTH-1:0] valid_in;
   logic valid_rd_ff;
   logic [7:0] ram_data;

   tpmm_ram #(
      .WIDTH(8),
      .DEPTH(tpmm_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(ram_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         valid_rd_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         valid_rd_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = valid_rd_ff ? ram_data : 8'h00;

endmodule

@@ src/tpmm_xlate.sv @@
module tpmm_xlate (
   input logic clock,
   input logic reset,
   input logic accept,
   input tpmm_pkg::stage_type stage,
   input logic [7:0] entry,
   input logic [10:0] ram_size_kb,
   output logic rsp_valid,
   output tpmm_pkg::rsp_type rsp_item
);

   tpmm_pkg::stage_type stage_ff;
   logic stage_valid_ff;
   tpmm_pkg::rsp_type rsp_ff;
   tpmm_pkg::rsp_type rsp_in;
   logic rsp_valid_ff;

   logic [15:0] addr;
   logic [tpmm_pkg::OFF_W-1:0] off;
   logic page_ram;
   logic rom_high;
   logic is_io;
   logic [19:0] phys;
   tpmm_pkg::target_type tgt;

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage;
      end
      if (stage_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_comb begin
      addr = stage_ff.item.cpu_address;
      off = addr[tpmm_pkg::OFF_W-1:0];
      page_ram = ({1'b0, entry, 2'b01} < ram_size_kb);
      rom_high = (entry > tpmm_pkg::ROM_PAGE_LAST_PLAIN);
      is_io = (addr >= tpmm_pkg::IO_START) && (addr < tpmm_pkg::TOP_WINDOW);
      phys = '0;
      tgt = tpmm_pkg::TGT_ROM;
      if (is_io) begin
         tgt = tpmm_pkg::TGT_IO;
      end else if (!stage_ff.map_on) begin
         if (addr < tpmm_pkg::ROM_UNMAPPED_START) begin
            tgt = tpmm_pkg::TGT_RAM;
            phys = {4'h0, addr};
         end else if (addr < tpmm_pkg::IO_START) begin
            phys = 20'(addr[tpmm_pkg::ROM_W-1:0]);
         end else begin
            phys = tpmm_pkg::ROM_TOP_BASE | {12'h000, addr[7:0]};
         end
      end else if (page_ram) begin
         tgt = tpmm_pkg::TGT_RAM;
         phys = {entry[7:0], off};
      end else if (addr >= tpmm_pkg::TOP_WINDOW) begin
         if (rom_high) begin
            phys = tpmm_pkg::ROM_TOP_BASE | {12'h000, addr[7:0]};
         end else begin
            phys = {12'h000, addr[7:0]};
         end
      end else if (rom_high) begin
         phys = 20'({entry[1:0], off});
      end else begin
         phys = 20'(off);
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.second_cpu_nmi = stage_ff.nmi;
      rsp_in.map_enabled = stage_ff.map_on;
      rsp_in.current_task = stage_ff.task_sel;
      unique case (tpmm_pkg::op_type'(stage_ff.item.operation))
         tpmm_pkg::OP_REG_READ: begin
            rsp_in.read_data = entry;
         end
         tpmm_pkg::OP_MEM_ACCESS: begin
            rsp_in.phys_address = phys;
            rsp_in.target = tgt;
            rsp_in.write_enable = stage_ff.item.is_write && (tgt == tpmm_pkg::TGT_RAM)
               && (stage_ff.item.data != tpmm_pkg::DATA_NO_WRITE);
         end
         tpmm_pkg::OP_REG_WRITE, tpmm_pkg::OP_CTRL_WRITE: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

@@ src/task_page_memory_mapper_top.sv @@
// Paged memory mapper: turns a 16-bit CPU address into a 20-bit RAM or ROM
// byte address or an I/O target through per-task page registers in one table memory.
// Commands enter on req_item and are taken at any clock edge where start is
// high; busy stays low, so a new command may be issued every cycle.
// Each command gives exactly one beat on rsp_item, marked by rsp_valid for
// one cycle, after the translation stage and response registers. The receiver
// must take every beat; there is no way to hold results back.
// Throughput is one command per clock. The page table is a single-port-read,
// single-port-write memory: a register write goes in on the edge that takes
// the command, and a lookup is read on that same edge, so the one read port
// sets the one-per-clock figure.
// The RAM size register is written through the csr_ channel, one beat
// carrying the size in kilobytes; it should only change while no command
// is in flight.
// Reset clears task select, mapping enable and NMI level, sets the RAM size
// to 256 KB and marks every page register as zero through a valid bit per
// entry, so no clearing pass is needed and commands are taken right away.
module task_page_memory_mapper_top (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input tpmm_pkg::req_type req_item,
   output logic rsp_valid,
   output tpmm_pkg::rsp_type rsp_item,
   input logic csr_valid,
   output logic csr_ready,
   input logic [10:0] csr_data
);

   logic accept;
   logic [3:0] task_ff;
   logic [3:0] task_in;
   logic map_on_ff;
   logic map_on_in;
   logic nmi_ff;
   logic nmi_in;
   logic [10:0] ram_size_ff;
   logic [3:0] row_index;
   logic [tpmm_pkg::TABLE_AW-1:0] table_addr;
   logic table_wr;
   logic [7:0] entry;
   tpmm_pkg::stage_type stage;

   // Every edge can take a command and every beat on the csr port is taken.
   assign busy = 1'b0;
   assign csr_ready = 1'b1;
   assign accept = start && !busy;

   // Control writes update the task, mapping enable and NMI on the accepting edge.
   always_comb begin
      task_in = task_ff;
      map_on_in = map_on_ff;
      nmi_in = nmi_ff;
      if (accept && (req_item.operation == tpmm_pkg::OP_CTRL_WRITE)) begin
         task_in = tpmm_pkg::task_of(req_item.data[3:0] & tpmm_pkg::CTRL_TASK_MASK[3:0]);
         map_on_in = !req_item.data[tpmm_pkg::CTRL_MAP_OFF_BIT];
         nmi_in = !req_item.data[tpmm_pkg::CTRL_NMI_OFF_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_ff <= '0;
         map_on_ff <= 1'b0;
         nmi_ff <= 1'b0;
         ram_size_ff <= tpmm_pkg::RAM_SIZE_RESET;
      end else begin
         task_ff <= task_in;
         map_on_ff <= map_on_in;
         nmi_ff <= nmi_in;
         if (csr_valid && csr_ready) begin
            ram_size_ff <= csr_data;
         end
      end
   end

   // Register commands index the row directly; memory accesses use the
   // logical page number. Both use the task selected before this command.
   assign row_index = (req_item.operation == tpmm_pkg::OP_MEM_ACCESS)
      ? req_item.cpu_address[15:12] : req_item.reg_index;
   assign table_addr = {task_ff[tpmm_pkg::TASK_W-1:0], row_index[tpmm_pkg::REG_W-1:0]};
   assign table_wr = accept && (req_item.operation == tpmm_pkg::OP_REG_WRITE);

   tpmm_table u_table (
      .clock(clock),
      .reset(reset),
      .wr_en(table_wr),
      .wr_addr(table_addr),
      .wr_data(req_item.data),
      .rd_addr(table_addr),
      .rd_entry(entry)
   );

   always_comb begin
      stage.item = req_item;
      stage.task_sel = task_in;
      stage.map_on = map_on_in;
      stage.nmi = nmi_in;
   end

   tpmm_xlate u_xlate (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .stage(stage),
      .entry(entry),
      .ram_size_kb(ram_size_ff),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

endmodule
